// ===== rtl/kat_pkg.sv =====
// Shared types and constants for the knob activity tracker.
`timescale 1ns / 1ps

package kat_pkg;

  localparam int unsigned FADE_MAX = 512;
  localparam int unsigned FADE_W   = $clog2(FADE_MAX + 1);
  localparam int unsigned POS_W    = 32;
  localparam int unsigned AXIS_W   = 8;
  localparam int unsigned CNT_W    = 8;
  localparam int unsigned LAMP_W   = 8;
  localparam int unsigned LAMP_SCALE = 255;

  localparam int unsigned DB_W    = 16;
  localparam int unsigned WRAP_W  = 31;
  localparam int unsigned IDLE_W  = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  localparam logic [DB_W-1:0]   DEADBAND_RST = DB_W'(15);
  localparam logic [WRAP_W-1:0] WRAP_RST     = WRAP_W'(1000);
  localparam logic [IDLE_W-1:0] IDLE_RST     = IDLE_W'(100);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADBAND  = 2'd0,
    REG_WRAP      = 2'd1,
    REG_IDLE      = 2'd2
  } cfg_reg_e;

  typedef logic signed [1:0] spin_t;
  localparam spin_t SPIN_ZERO = 2'sb00;
  localparam spin_t SPIN_FWD  = 2'sb01;
  localparam spin_t SPIN_REV  = 2'sb11;

  typedef struct packed {
    logic [DB_W-1:0]   deadband;
    logic [WRAP_W-1:0] wrap_threshold;
    logic [IDLE_W-1:0] idle_limit;
  } cfg_t;

  // Per-channel values after one tick
  typedef struct packed {
    logic [AXIS_W-1:0] axis;
    spin_t             spin;
    logic [FADE_W-1:0] fade;
    spin_t             held;
  } chan_res_t;

endpackage

// ===== rtl/kat_channel.sv =====
// One knob channel: deadband filter, spin direction, idle counter, fade and held spin.
`timescale 1ns / 1ps

module kat_channel (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    step_i,
  input  logic [kat_pkg::POS_W-1:0] pos_i,
  input  kat_pkg::cfg_t           cfg_i,
  output kat_pkg::chan_res_t      res_o
);
  import kat_pkg::*;

  localparam logic [FADE_W-1:0] FADE_TOP = FADE_W'(FADE_MAX);

  logic [POS_W-1:0]  last_q, last_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  spin_t             spin_q, spin_d;
  logic [FADE_W-1:0] fade_q, fade_d;
  spin_t             held_q, held_d;

  logic [POS_W-1:0]   delta;
  logic signed [POS_W:0] delta_ext, db_ext, fall_diff, wrap_ext;
  logic               in_band;
  logic [POS_W-1:0]   filt;
  logic [CNT_W-1:0]   cnt_inc;

  always_comb begin
    delta     = pos_i - last_q;
    delta_ext = $signed({delta[POS_W-1], delta});
    db_ext    = $signed({{(POS_W + 1 - DB_W){1'b0}}, cfg_i.deadband});
    in_band   = (delta_ext <= db_ext) && (delta_ext >= -db_ext);
    filt      = in_band ? last_q : pos_i;

    // exact fall size, no wrap
    fall_diff = $signed({last_q[POS_W-1], last_q}) - $signed({filt[POS_W-1], filt});
    wrap_ext  = $signed({{(POS_W + 1 - WRAP_W){1'b0}}, cfg_i.wrap_threshold});
    cnt_inc   = cnt_q + CNT_W'(1);

    spin_d = spin_q;
    cnt_d  = cnt_q;
    if (filt == last_q) begin
      cnt_d = cnt_inc;
      if (cnt_inc == CNT_W'(cfg_i.idle_limit)) begin
        spin_d = SPIN_ZERO;
        cnt_d  = '0;
      end
    end else if (($signed(filt) > $signed(last_q)) || (fall_diff > wrap_ext)) begin
      spin_d = SPIN_FWD;
    end else begin
      spin_d = SPIN_REV;
    end

    last_d = filt;

    fade_d = fade_q;
    if (spin_d != SPIN_ZERO) begin
      if (fade_q < FADE_TOP) fade_d = fade_q + FADE_W'(1);
    end else begin
      if (fade_q != '0) fade_d = fade_q - FADE_W'(1);
    end

    held_d = (spin_d != SPIN_ZERO) ? spin_d : held_q;
    if (fade_d == '0) held_d = SPIN_ZERO;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
      cnt_q  <= '0;
      spin_q <= SPIN_ZERO;
      fade_q <= '0;
      held_q <= SPIN_ZERO;
    end else if (step_i) begin
      last_q <= last_d;
      cnt_q  <= cnt_d;
      spin_q <= spin_d;
      fade_q <= fade_d;
      held_q <= held_d;
    end
  end

  assign res_o.axis = filt[AXIS_W+1:2];
  assign res_o.spin = spin_d;
  assign res_o.fade = fade_d;
  assign res_o.held = held_d;

endmodule

// ===== rtl/knob_activity_tracker.sv =====
// Top level: two knob channels, config registers and the report output register.
// An accepted tick's report beat shows on the master side in the cycle after it is taken.
// Throughput: one tick per cycle while the master side takes each beat; the output register frees as its beat is taken.
// Each channel's state and the report are both loaded at the accepting edge.
// Reset (async, active low) clears channel state and the output valid, and loads
// the register defaults: deadband 15, wrap threshold 1000, idle limit 100.
`timescale 1ns / 1ps

module knob_activity_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side: buttons[15:0], pos_left[47:16], pos_right[79:48]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [79:0] s_axis_tdata,
  // master side: report_buttons[15:0], axis_left[23:16], axis_right[31:24],
  // dir_left[33:32], dir_right[35:34], glow_left[45:36], glow_right[55:46],
  // sticky_dir_left[57:56], sticky_dir_right[59:58], lamp_level[67:60], zero pad[71:68]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,
  // config write channel
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [kat_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [kat_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  import kat_pkg::*;

  cfg_t        cfg_q;
  logic        accept;
  chan_res_t   res_l, res_r;
  logic [FADE_W-1:0]         top_fade;
  logic [FADE_W+LAMP_W-1:0]  lamp_prod;
  logic [LAMP_W-1:0]         lamp;
  logic        out_valid_q, out_valid_d;
  logic [71:0] out_data_q, out_data_d;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.deadband       <= DEADBAND_RST;
      cfg_q.wrap_threshold <= WRAP_RST;
      cfg_q.idle_limit     <= IDLE_RST;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_DEADBAND: cfg_q.deadband       <= cfg_data_i[DB_W-1:0];
        REG_WRAP:     cfg_q.wrap_threshold <= cfg_data_i[WRAP_W-1:0];
        REG_IDLE:     cfg_q.idle_limit     <= cfg_data_i[IDLE_W-1:0];
        default: ;
      endcase
    end
  end

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;

  kat_channel u_left (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .pos_i  (s_axis_tdata[47:16]),
    .cfg_i  (cfg_q),
    .res_o  (res_l)
  );

  kat_channel u_right (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .pos_i  (s_axis_tdata[79:48]),
    .cfg_i  (cfg_q),
    .res_o  (res_r)
  );

  always_comb begin
    top_fade  = (res_l.fade > res_r.fade) ? res_l.fade : res_r.fade;
    lamp_prod = (FADE_W + LAMP_W)'(top_fade) * (FADE_W + LAMP_W)'(LAMP_SCALE);
    lamp      = LAMP_W'(lamp_prod / FADE_MAX);
    out_data_d = {4'b0000, lamp, res_r.held, res_l.held, res_r.fade, res_l.fade,
                  res_r.spin, res_l.spin, res_r.axis, res_l.axis, s_axis_tdata[15:0]};
    out_valid_d = accept || (out_valid_q && !m_axis_tready);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= out_data_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/kat_checker.sv =====
// Port-level checks for the knob activity tracker, bound to the top level.
`timescale 1ns / 1ps

module kat_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  // an accepted tick always shows up as a report beat on the next cycle
  a_tick_to_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> m_axis_tvalid)
    else $error("accepted tick produced no report beat");

  // an empty output register never back-pressures the input
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output register");

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("report beat dropped or changed while stalled");

  // left held spin is zero whenever its fade level is zero
  a_sticky_fade: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && (m_axis_tdata[45:36] == 10'd0)) |-> (m_axis_tdata[57:56] == 2'b00))
    else $error("left held spin set with zero fade");

  a_reset_empty: assert property (@(posedge clk_i)
    !rst_ni |=> !m_axis_tvalid)
    else $error("report valid right after reset");

endmodule

bind knob_activity_tracker kat_checker u_kat_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

// ===== test/testbench.sv =====
// Self-checking testbench for the knob activity tracker: poll ticks in, checked reports out.
`timescale 1ns / 1ps

module testbench;
  import kat_pkg::*;

  localparam int STALL_LIMIT     = 2000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct packed {
    logic [POS_W-1:0] pos_right;
    logic [POS_W-1:0] pos_left;
    logic [15:0]      buttons;
  } poll_tick_t;

  typedef struct packed {
    logic [LAMP_W-1:0] lamp;
    spin_t             held_r;
    spin_t             held_l;
    logic [FADE_W-1:0] glow_r;
    logic [FADE_W-1:0] glow_l;
    spin_t             dir_r;
    spin_t             dir_l;
    logic [AXIS_W-1:0] axis_r;
    logic [AXIS_W-1:0] axis_l;
    logic [15:0]       buttons;
  } knob_report_t;

  typedef struct packed {
    logic [POS_W-1:0]  last;
    logic [CNT_W-1:0]  still;
    spin_t             spin;
    logic [FADE_W-1:0] fade;
    spin_t             held;
  } knob_state_t;

  typedef enum int {MOTION_MIX, MOTION_SPIN, MOTION_HOLD} motion_e;

  logic        clk_i;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [79:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // predictor copy of the registers and channel state
  logic [DB_W-1:0]   deadband_reg = DEADBAND_RST;
  logic [WRAP_W-1:0] wrap_reg     = WRAP_RST;
  logic [IDLE_W-1:0] idle_reg     = IDLE_RST;
  knob_state_t       knobs [2];

  poll_tick_t   pending_ticks [$];
  knob_report_t report_q [$];

  int ticks_issued, ticks_accepted, reports_checked, reg_writes;
  int mismatch_count, idle_clears, peak_fade;
  int send_gap_pct, recv_gap_pct;
  int stall_cycles, quiet_cycles;
  bit stall_request, tick_beat;
  logic [POS_W-1:0] gen_left, gen_right;

  knob_activity_tracker i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // One channel for one tick; returns the position after the deadband filter.
  function automatic logic [POS_W-1:0] advance_knob(input int side, input logic [POS_W-1:0] raw);
    knob_state_t             k;
    logic [POS_W-1:0]        kept;
    logic signed [POS_W-1:0] delta;
    longint                  delta_v, prev_v, pos_v;
    k = knobs[side];
    kept = raw;
    delta = raw - k.last;
    delta_v = delta;
    if (delta_v >= -longint'(deadband_reg) && delta_v <= longint'(deadband_reg)) kept = k.last;
    prev_v = $signed(k.last);
    pos_v = $signed(kept);
    if (pos_v == prev_v) begin
      k.still = k.still + 1'b1;
      if (k.still == idle_reg) begin
        k.spin = SPIN_ZERO;
        k.still = '0;
        idle_clears++;
      end
    end else if (pos_v > prev_v || prev_v - pos_v > longint'(wrap_reg)) begin
      k.spin = SPIN_FWD;
    end else begin
      k.spin = SPIN_REV;
    end
    k.last = kept;
    if (k.spin != SPIN_ZERO) begin
      if (k.fade < FADE_MAX) k.fade = k.fade + 1'b1;
    end else if (k.fade > 0) begin
      k.fade = k.fade - 1'b1;
    end
    if (k.spin != SPIN_ZERO) k.held = k.spin;
    if (k.fade == 0) k.held = SPIN_ZERO;
    knobs[side] = k;
    return kept;
  endfunction

  function automatic knob_report_t forecast_report(input poll_tick_t t);
    knob_report_t     r;
    logic [POS_W-1:0] kept_l, kept_r;
    int unsigned      top_fade;
    kept_l = advance_knob(0, t.pos_left);
    kept_r = advance_knob(1, t.pos_right);
    top_fade = (knobs[0].fade > knobs[1].fade) ? knobs[0].fade : knobs[1].fade;
    if (top_fade > peak_fade) peak_fade = top_fade;
    r.buttons = t.buttons;
    r.axis_l  = kept_l[AXIS_W+1:2];
    r.axis_r  = kept_r[AXIS_W+1:2];
    r.dir_l   = knobs[0].spin;
    r.dir_r   = knobs[1].spin;
    r.glow_l  = knobs[0].fade;
    r.glow_r  = knobs[1].fade;
    r.held_l  = knobs[0].held;
    r.held_r  = knobs[1].held;
    r.lamp    = LAMP_W'(top_fade * LAMP_SCALE / FADE_MAX);
    return r;
  endfunction

  task automatic check_field(input string label, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      mismatch_count++;
      if (mismatch_count <= 10)
        $display("report %0d: %s expected 0x%0h, got 0x%0h", reports_checked, label, want, got);
    end
  endtask

  // Monitor: predicts on every accepted tick, applies register writes, checks reports.
  always @(posedge clk_i) begin
    knob_report_t want, got;
    if (rst_ni) begin
      tick_beat = s_axis_tvalid && s_axis_tready;
      if (tick_beat) begin
        report_q.push_back(forecast_report(poll_tick_t'(s_axis_tdata)));
        ticks_accepted++;
      end
      if (cfg_valid_i && cfg_ready_o) begin
        reg_writes++;
        case (cfg_index_i)
          REG_DEADBAND: deadband_reg = cfg_data_i[DB_W-1:0];
          REG_WRAP:     wrap_reg = cfg_data_i[WRAP_W-1:0];
          REG_IDLE:     idle_reg = cfg_data_i[IDLE_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got = knob_report_t'(m_axis_tdata[67:0]);
        if (report_q.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("report beat 0x%0h with nothing expected", m_axis_tdata);
        end else begin
          want = report_q.pop_front();
          check_field("report_buttons", want.buttons, got.buttons);
          check_field("axis_left", want.axis_l, got.axis_l);
          check_field("axis_right", want.axis_r, got.axis_r);
          check_field("dir_left", want.dir_l, got.dir_l);
          check_field("dir_right", want.dir_r, got.dir_r);
          check_field("glow_left", want.glow_l, got.glow_l);
          check_field("glow_right", want.glow_r, got.glow_r);
          check_field("sticky_dir_left", want.held_l, got.held_l);
          check_field("sticky_dir_right", want.held_r, got.held_r);
          check_field("lamp_level", want.lamp, got.lamp);
          check_field("pad", 0, m_axis_tdata[71:68]);
          reports_checked++;
        end
      end
    end else begin
      tick_beat = 1'b0;
    end
  end

  // Driver: a new tick goes out only once the previous one was taken.
  always @(negedge clk_i) begin
    poll_tick_t t;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else if (!s_axis_tvalid || tick_beat) begin
      if (pending_ticks.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        t = pending_ticks.pop_front();
        s_axis_tdata  <= t;
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // Report side backpressure, with an occasional long hold-off.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else if (stall_request) begin
      stall_request = 1'b0;
      stall_cycles  = HOLD_OFF_CYCLES;
      m_axis_tready <= 1'b0;
    end else if (stall_cycles > 0) begin
      stall_cycles--;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_gap_pct);
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles == STALL_LIMIT) begin
        $display("watchdog: no beat for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic queue_tick(input logic [15:0] buttons, input logic [POS_W-1:0] left,
                            input logic [POS_W-1:0] right);
    poll_tick_t t;
    t.buttons   = buttons;
    t.pos_left  = left;
    t.pos_right = right;
    gen_left    = left;
    gen_right   = right;
    pending_ticks.push_back(t);
    ticks_issued++;
  endtask

  function automatic logic [POS_W-1:0] next_position(input logic [POS_W-1:0] cur,
                                                     input motion_e style);
    int               pick;
    logic [POS_W-1:0] step;
    pick = $urandom_range(99);
    if (style == MOTION_HOLD) return cur;
    if (style == MOTION_SPIN) begin
      step = deadband_reg + 1 + $urandom_range(63);
      return $urandom_range(1) ? cur + step : cur - step;
    end
    if (pick < 30) return cur;
    if (pick < 45) begin
      // jitter that the deadband should swallow
      step = $urandom_range(deadband_reg);
      return $urandom_range(1) ? cur + step : cur - step;
    end
    if (pick < 80) begin
      step = deadband_reg + 1 + $urandom_range(299);
      return $urandom_range(1) ? cur + step : cur - step;
    end
    if (pick < 90) return $urandom;
    case ($urandom_range(3))
      0:       step = 32'h7FFF_FFFF;
      1:       step = 32'h8000_0000;
      2:       step = 32'h0000_0000;
      default: step = 32'hFFFF_FFFF;
    endcase
    return step + $urandom_range(6) - 3;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  // Writes all three registers; upper data bits are junk that must be dropped.
  task automatic set_knob_regs(input logic [DB_W-1:0] db, input logic [WRAP_W-1:0] wrap,
                               input logic [IDLE_W-1:0] idle);
    write_reg(REG_DEADBAND, {16'($urandom), db});
    write_reg(REG_WRAP, {1'($urandom), wrap});
    write_reg(REG_IDLE, {24'($urandom), idle});
  endtask

  // Waits until every tick is taken and every report is back.
  task automatic drain;
    while (ticks_accepted != ticks_issued || report_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic run_phase(input int n, input int send_gap, input int recv_gap,
                           input motion_e style_l, input motion_e style_r, input bit hold_off);
    send_gap_pct = send_gap;
    recv_gap_pct = recv_gap;
    if (hold_off) begin
      @(posedge clk_i);
      stall_request = 1'b1;
    end
    repeat (n)
      queue_tick(16'($urandom), next_position(gen_left, style_l),
                 next_position(gen_right, style_r));
    drain();
  endtask

  initial begin
    knobs[0] = '0;
    knobs[1] = '0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, deadband edges, wrap threshold edges, 32-bit wrap
    queue_tick(16'h0000, 32'h0000_0000, 32'h0000_0000);
    queue_tick(16'hFFFF, 32'd15, 32'hFFFF_FFF1);
    queue_tick(16'h5555, 32'd16, 32'hFFFF_FFF0);
    queue_tick(16'hAAAA, 32'hFFFF_FC28, 32'hFFFF_FC07);  // fall of 1000 vs 1001
    queue_tick(16'h8001, 32'h7FFF_FFFF, 32'h8000_0000);
    queue_tick(16'h0001, 32'h8000_0000, 32'h7FFF_FFFF);  // one-count wrap stays in deadband
    queue_tick(16'h8000, 32'h8000_0010, 32'h7FFF_FFF0);
    queue_tick(16'h1234, 32'hFFFF_FFFF, 32'h0000_0000);
    queue_tick(16'hFEDC, 32'd14, 32'd15);
    queue_tick(16'h00FF, 32'd15, 32'd16);
    repeat (6) queue_tick(16'($urandom), 32'd15, 32'd16);
    queue_tick(16'hFF00, 32'h0000_03FC, 32'h0000_0000);
    drain();

    set_knob_regs(16'd0, 31'd0, 8'd1);
    run_phase(100, 46, 0, MOTION_MIX, MOTION_MIX, 1'b0);

    set_knob_regs(16'hFFFF, 31'h7FFF_FFFF, 8'd255);
    write_reg(REG_UNUSED, $urandom);
    run_phase(100, 0, 46, MOTION_MIX, MOTION_MIX, 1'b1);

    // idle limit zero: left clears only after the counter wraps; right fades to the top
    set_knob_regs(16'd3, 31'd1000, 8'd0);
    run_phase(560, 38, 38, MOTION_HOLD, MOTION_SPIN, 1'b0);

    set_knob_regs(16'd15, 31'd200, 8'd5);
    run_phase(100, 0, 0, MOTION_MIX, MOTION_MIX, 1'b0);

    repeat (8) @(posedge clk_i);
    $display("covered %0d ticks, %0d reports checked, %0d register writes", ticks_accepted,
             reports_checked, reg_writes);
    $display("idle clears %0d, peak fade %0d, mismatches %0d", idle_clears, peak_fade,
             mismatch_count);
    if (mismatch_count == 0 && report_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
